// ===== src/bmv_pkg.sv =====
// Shared types and constants for the block mean/variance unit.
`timescale 1ns / 1ps
package bmv_pkg;

  localparam int SAMPLE_WIDTH     = 24;
  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int VAR_W            = 48;
  localparam int TOTAL_W          = 11;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
    logic                           is_last;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] mean_value;
    logic [VAR_W-1:0]               variance_value;
    logic [TOTAL_W-1:0]             element_total;
    logic                           overflow_flag;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MEAN_GO,
    ST_MEAN_DIV,
    ST_SQ,
    ST_VAR_GO,
    ST_VAR_DIV
  } bmv_state_t;

endpackage

// ===== src/bmv_ram.sv =====
// Simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module bmv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bmv_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bmv_div #(
  parameter int NUM_W = 59,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    step_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= CW'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== src/block_mean_variance.sv =====
// Top level: block mean and population variance over stored samples.
`timescale 1ns / 1ps
// Samples are taken one per cycle while busy is low and written into an
// on-chip sample RAM; the marked last sample closes the block. A block then
// runs two passes: the mean comes from a bit-serial divider (one quotient bit
// per cycle), the stored samples are read back once each through a four-stage
// read/subtract/square/accumulate pipeline, and the divider runs again for the
// variance. busy stays high from the cycle after the last sample until the
// result cycle. The result is shown for exactly one cycle on out_valid and
// must be taken then; the receiver cannot stall it. Samples past the RAM depth
// are dropped and reported in overflow_flag.
module block_mean_variance #(
  parameter int MAX_ELEMENTS = bmv_pkg::MAX_ELEMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bmv_pkg::in_req_t  in_data,
  output logic              out_valid,
  output bmv_pkg::out_res_t out_data
);

  import bmv_pkg::*;

  localparam int AW     = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
  localparam int DIFF_W = SAMPLE_WIDTH + 1;
  localparam int SQ_W   = 2 * SAMPLE_WIDTH;
  localparam int ACC_W  = SQ_W + CNT_W;

  bmv_state_t state_r, state_nxt;

  logic signed [SUM_W-1:0]        sum_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           drop_r;
  logic signed [SAMPLE_WIDTH-1:0] mean_r;
  logic [CNT_W-1:0]               idx_r;
  logic                           rd_v_r;
  logic                           mag_v_r;
  logic                           sq_v_r;
  logic [SAMPLE_WIDTH-1:0]        mag_r;
  logic [SQ_W-1:0]                sq_r;
  logic [ACC_W-1:0]               acc_r;
  logic                           out_valid_r;
  out_res_t                       out_data_r;

  logic                           accept;
  logic                           has_room;
  logic                           rd_en;
  logic                           pass_done;
  logic                           div_start;
  logic                           div_done;
  logic [ACC_W-1:0]               div_num;
  logic [ACC_W-1:0]               div_quo;
  logic [SAMPLE_WIDTH-1:0]        rd_raw;
  logic signed [SUM_W-1:0]        x_ext;
  logic [SUM_W-1:0]               sum_mag;
  logic signed [DIFF_W-1:0]       diff;
  logic [SAMPLE_WIDTH-1:0]        diff_mag;
  logic [SAMPLE_WIDTH-1:0]        quo_mag;

  assign busy     = (state_r != ST_LOAD);
  assign accept   = start && !busy;
  assign has_room = cnt_r < CNT_W'(MAX_ELEMENTS);
  assign rd_en    = (state_r == ST_SQ) && (idx_r != cnt_r);
  assign pass_done = (idx_r == cnt_r) && !rd_v_r && !mag_v_r && !sq_v_r;

  assign x_ext   = SUM_W'(in_data.sample_value);
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign diff    = DIFF_W'($signed(rd_raw)) - DIFF_W'(mean_r);
  assign diff_mag = diff[DIFF_W-1] ? SAMPLE_WIDTH'(-diff) : SAMPLE_WIDTH'(diff);
  assign quo_mag = div_quo[SAMPLE_WIDTH-1:0];
  assign div_num = (state_r == ST_MEAN_GO) ? ACC_W'(sum_mag) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (accept && in_data.is_last) begin
          state_nxt = ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: begin
        div_start = 1'b1;
        state_nxt = ST_MEAN_DIV;
      end
      ST_MEAN_DIV: begin
        if (div_done) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (pass_done) begin
          state_nxt = ST_VAR_GO;
        end
      end
      ST_VAR_GO: begin
        div_start = 1'b1;
        state_nxt = ST_VAR_DIV;
      end
      ST_VAR_DIV: begin
        if (div_done) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // block accumulation and second-pass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      idx_r       <= '0;
      rd_v_r      <= 1'b0;
      mag_v_r     <= 1'b0;
      sq_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_v_r      <= rd_en;
      mag_v_r     <= rd_v_r;
      sq_v_r      <= mag_v_r;
      if (accept) begin
        if (has_room) begin
          sum_r <= sum_r + x_ext;
          cnt_r <= cnt_r + 1'b1;
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (state_r == ST_MEAN_GO) begin
        idx_r <= '0;
      end else if (rd_en) begin
        idx_r <= idx_r + 1'b1;
      end
      if (state_r == ST_VAR_DIV && div_done) begin
        out_valid_r <= 1'b1;
        sum_r       <= '0;
        cnt_r       <= '0;
        drop_r      <= 1'b0;
      end
    end
  end

  // datapath: mean capture, deviation pipeline, result
  always_ff @(posedge clk) begin
    if (state_r == ST_MEAN_DIV && div_done) begin
      mean_r <= sum_r[SUM_W-1] ? SAMPLE_WIDTH'(-quo_mag) : quo_mag;
    end
    mag_r <= diff_mag;
    sq_r  <= mag_r * mag_r;
    if (state_r == ST_MEAN_GO) begin
      acc_r <= '0;
    end else if (sq_v_r) begin
      acc_r <= acc_r + ACC_W'(sq_r);
    end
    if (state_r == ST_VAR_DIV && div_done) begin
      out_data_r.mean_value     <= mean_r;
      out_data_r.variance_value <= (div_quo[ACC_W-1:VAR_W] != '0) ? '1
                                   : div_quo[VAR_W-1:0];
      out_data_r.element_total  <= TOTAL_W'(cnt_r);
      out_data_r.overflow_flag  <= drop_r;
    end
  end

  bmv_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && has_room),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_data.sample_value),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_raw)
  );

  bmv_div #(
    .NUM_W (ACC_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (cnt_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while block busy");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ELEMENTS))
    else $error("stored count beyond capacity");

  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.is_last) |=> busy)
    else $error("last request did not start computation");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ) |-> (idx_r <= cnt_r))
    else $error("second pass read index past stored count");
`endif

endmodule
